[sv/fpba_pkg.sv]
// fpba_pkg: shared codes and types of the fit-policy block allocator
// no dependencies; imported by fpba_scan_eval and the top level
`default_nettype none

package fpba_pkg;

	// action codes of an input beat
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// fit policy register codes
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_ZERO    = 2'd3;

	// configuration register indexes
	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_REGION = 1'b1;

	// verdict of the shared compare unit on one table entry
	typedef struct packed {
		logic fit;      // free and long enough
		logic select;   // fits and beats the current candidate
		logic match;    // data offset equals the offset to free
	} eval_t;

endpackage

`default_nettype wire

[sv/fit_policy_block_allocator_top.sv]
// allocate scans the table, then on a split shifts the table tail and writes the new free entry
// free scans the table, plus up to two shifts of the table tail on merges
// clear rebuilds entry 0; one beat at a time, set by the single read port of the table memory
// throughput: one beat per operation, input stalled until the result beat is taken
// reset: control and configuration registers set at once, entry 0 rebuilt in the first cycle while input stalls
// fit_policy_block_allocator_top: sequencer, segment table memory and compare unit
// depends on fpba_pkg, fpba_ram, fpba_scan_eval
`default_nettype none

module fit_policy_block_allocator_top #(
	parameter int MAX_SEGMENTS = 64,
	parameter int HEADER_BYTES = 32,
	parameter int OFFSET_BITS  = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration
	input  wire                                   cfg_we,
	input  wire                                   cfg_index,
	input  wire  [OFFSET_BITS-1:0]                cfg_data,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [1:0]                            action,
	input  wire  [OFFSET_BITS-1:0]                request_size,
	input  wire  [OFFSET_BITS-1:0]                block_offset,
	// output channel
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [1:0]                            status,
	output logic [OFFSET_BITS-1:0]                granted_offset,
	output logic [OFFSET_BITS-1:0]                bytes_free,
	output logic [$clog2(MAX_SEGMENTS+1)-1:0]     segment_total
);

	import fpba_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int OB = OFFSET_BITS;
	localparam int EW = 2 * OB + 1;
	localparam logic [OB-1:0] HB       = OB'(HEADER_BYTES);
	localparam logic [OB:0]   HB_WIDE  = (OB+1)'(HEADER_BYTES);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SEGMENTS);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);
	localparam logic [CW-1:0] CNT_TWO  = CW'(2);
	localparam logic [OB-1:0] REGION_RESET = OB'(2000);

	typedef enum logic [11:0] {
		S_INIT = 12'b0000_0000_0001,
		S_IDLE = 12'b0000_0000_0010,
		S_SCAN = 12'b0000_0000_0100,
		S_AFIN = 12'b0000_0000_1000,
		S_MOVE = 12'b0000_0001_0000,
		S_WNEW = 12'b0000_0010_0000,
		S_WK   = 12'b0000_0100_0000,
		S_FCHK = 12'b0000_1000_0000,
		S_FSUC = 12'b0001_0000_0000,
		S_FPRE = 12'b0010_0000_0000,
		S_FMP  = 12'b0100_0000_0000,
		S_RESP = 12'b1000_0000_0000
	} state_t;

	state_t state_q, ret_q;

	// configuration registers
	logic [1:0]    policy_q;
	logic [OB-1:0] region_q;

	// allocator state
	logic [CW-1:0] count_q;
	logic [CW-1:0] cur_q;
	logic          cur_vld_q;
	logic [OB-1:0] free_q;

	// captured beat
	logic [1:0]    act_q;
	logic [OB-1:0] size_q;
	logic [OB-1:0] ofs_q;
	logic          init_reply_q;

	// scan and move bookkeeping
	logic [CW-1:0] iss_n_q;
	logic [IW-1:0] iss_j_q;
	logic          pend_q;
	logic [IW-1:0] pend_a_q;
	logic [IW-1:0] mv_r_q;
	logic [IW-1:0] mv_last_q;
	logic          mv_up_q;
	logic          mv_done_q;

	// chosen entry and its neighbors
	logic          found_q;
	logic [IW-1:0] k_q;
	logic [OB-1:0] k_start_q;
	logic [OB-1:0] k_len_q;
	logic          k_used_q;
	logic          succ_free_q;
	logic [OB-1:0] succ_len_q;
	logic          pred_free_q;
	logic [OB-1:0] pred_start_q;
	logic [OB-1:0] pred_len_q;

	// result registers
	logic [1:0]    status_q;
	logic [OB-1:0] granted_q;

	// memory ports
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic [OB-1:0] rd_start;
	logic [OB-1:0] rd_len;
	logic          rd_used;

	eval_t         ev;

	// combinational helpers
	logic          op_free;
	logic          stop_mode;
	logic          sel;
	logic          scan_issue;
	logic [OB-1:0] len0;
	logic [CW-1:0] k_cw;
	logic          split;
	logic [OB-1:0] merged_len;
	logic [CW-1:0] afin_cur, fpre_cur, fmp_cur;
	logic          afin_vld, fpre_vld, fmp_vld;
	logic [CW-1:0] nf_start;
	logic          nf_reset;

	fpba_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_used  = ram_rdata[0];
	assign rd_len   = ram_rdata[OB:1];
	assign rd_start = ram_rdata[2*OB:OB+1];

	fpba_scan_eval #(
		.OFFSET_BITS (OB),
		.HEADER_BYTES(HEADER_BYTES)
	) u_eval (
		.entry_start (rd_start),
		.entry_len   (rd_len),
		.entry_used  (rd_used),
		.request_size(size_q),
		.block_offset(ofs_q),
		.best_len    (k_len_q),
		.found       (found_q),
		.policy      (policy_q),
		.verdict     (ev)
	);

	// scan control and derived values
	always_comb begin
		op_free    = (act_q == ACT_FREE);
		stop_mode  = op_free || policy_q == POL_FIRST || policy_q == POL_NEXT;
		sel        = pend_q && (op_free ? ev.match : ev.select);
		scan_issue = (iss_n_q < count_q) && !(sel && stop_mode);
		len0       = ({1'b0, region_q} > HB_WIDE) ? (region_q - HB) : '0;
		k_cw       = CW'(k_q);
		split      = ({1'b0, k_len_q} > ({1'b0, size_q} + HB_WIDE)) && (count_q < CNT_MAX);
		merged_len = succ_free_q ? (k_len_q + HB + succ_len_q) : k_len_q;
		nf_reset   = !cur_vld_q || (cur_q >= count_q);
		nf_start   = nf_reset ? '0 : cur_q;
	end

	// next-fit cursor after a grant, then after the split insert
	always_comb begin
		afin_cur = cur_q;
		afin_vld = cur_vld_q;
		if (policy_q == POL_NEXT) begin
			if (k_cw + CNT_ONE < count_q) begin
				afin_cur = k_cw + CNT_ONE;
			end else begin
				afin_vld = 1'b0;
			end
		end
		if (split && afin_vld && afin_cur > k_cw) begin
			afin_cur = afin_cur + CNT_ONE;
		end
	end

	// cursor after a successor merge and its removal
	always_comb begin
		fpre_cur = cur_q;
		fpre_vld = cur_vld_q;
		if (succ_free_q) begin
			if (fpre_vld && fpre_cur == k_cw + CNT_ONE) begin
				if (k_cw + CNT_TWO < count_q) begin
					fpre_cur = k_cw + CNT_TWO;
				end else begin
					fpre_vld = 1'b0;
				end
			end
			if (fpre_vld) begin
				if (fpre_cur == k_cw + CNT_ONE) begin
					fpre_vld = 1'b0;
				end else if (fpre_cur > k_cw + CNT_ONE) begin
					fpre_cur = fpre_cur - CNT_ONE;
				end
			end
		end
	end

	// cursor after a predecessor merge and its removal
	always_comb begin
		fmp_cur = cur_q;
		fmp_vld = cur_vld_q;
		if (fmp_vld && fmp_cur == k_cw) begin
			fmp_cur = k_cw - CNT_ONE;
		end
		if (fmp_vld) begin
			if (fmp_cur == k_cw) begin
				fmp_vld = 1'b0;
			end else if (fmp_cur > k_cw) begin
				fmp_cur = fmp_cur - CNT_ONE;
			end
		end
	end

	// table memory port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = {k_start_q, k_len_q, 1'b0};
		ram_raddr = iss_j_q;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {{OB{1'b0}}, len0, 1'b0};
			end
			S_SCAN: begin
				ram_raddr = iss_j_q;
			end
			S_MOVE: begin
				ram_raddr = mv_r_q;
				ram_we    = pend_q;
				ram_waddr = mv_up_q ? (pend_a_q - 1'b1) : (pend_a_q + 1'b1);
				ram_wdata = ram_rdata;
			end
			S_WNEW: begin
				ram_we    = 1'b1;
				ram_waddr = k_q + 1'b1;
				ram_wdata = {k_start_q + HB + size_q, k_len_q - size_q - HB, 1'b0};
			end
			S_WK: begin
				ram_we    = 1'b1;
				ram_wdata = {k_start_q, k_len_q, 1'b1};
			end
			S_FCHK: begin
				ram_raddr = k_q + 1'b1;
			end
			S_FSUC: begin
				ram_raddr = k_q - 1'b1;
			end
			S_FPRE: begin
				ram_we    = 1'b1;
				ram_wdata = {k_start_q, merged_len, 1'b0};
			end
			S_FMP: begin
				ram_we    = pred_free_q;
				ram_waddr = k_q - 1'b1;
				ram_wdata = {pred_start_q, pred_len_q + HB + k_len_q, 1'b0};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			region_q <= REGION_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY: policy_q <= cfg_data[1:0];
				CFG_REGION: region_q <= cfg_data;
				default:    policy_q <= policy_q;
			endcase
		end
	end

	// payload of the captured beat and chosen entry
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q  <= action;
			size_q <= request_size;
			ofs_q  <= block_offset;
		end
		if (state_q == S_SCAN && sel) begin
			k_q       <= pend_a_q;
			k_start_q <= rd_start;
			k_len_q   <= rd_len;
			k_used_q  <= rd_used;
		end
		if (state_q == S_FSUC) begin
			succ_free_q <= (k_cw + CNT_ONE < count_q) && !rd_used;
			succ_len_q  <= rd_len;
		end
		if (state_q == S_FPRE) begin
			pred_free_q  <= (k_q != '0) && !rd_used;
			pred_start_q <= rd_start;
			pred_len_q   <= rd_len;
			k_len_q      <= merged_len;
		end
		if (state_q == S_WNEW) begin
			k_len_q <= size_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ret_q        <= S_RESP;
			init_reply_q <= 1'b0;
			count_q      <= CNT_ONE;
			cur_q        <= '0;
			cur_vld_q    <= 1'b0;
			free_q       <= '0;
			iss_n_q      <= '0;
			iss_j_q      <= '0;
			pend_q       <= 1'b0;
			pend_a_q     <= '0;
			mv_r_q       <= '0;
			mv_last_q    <= '0;
			mv_up_q      <= 1'b0;
			mv_done_q    <= 1'b0;
			found_q      <= 1'b0;
			status_q     <= ST_OK;
			granted_q    <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					count_q   <= CNT_ONE;
					cur_q     <= '0;
					cur_vld_q <= 1'b0;
					free_q    <= len0;
					state_q   <= init_reply_q ? S_RESP : S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						status_q  <= (action == ACT_ALLOC && request_size == '0) ?
							ST_ZERO : ST_OK;
						granted_q <= '0;
						found_q   <= 1'b0;
						pend_q    <= 1'b0;
						iss_n_q   <= '0;
						// next fit starts its scan at the cursor
						iss_j_q   <= (action == ACT_ALLOC && policy_q == POL_NEXT) ?
							nf_start[IW-1:0] : '0;
						unique case (action)
							ACT_CLEAR: begin
								init_reply_q <= 1'b1;
								state_q      <= S_INIT;
							end
							ACT_ALLOC: begin
								if (request_size == '0) begin
									state_q  <= S_RESP;
								end else begin
									if (policy_q == POL_NEXT && nf_reset) begin
										cur_q     <= '0;
										cur_vld_q <= 1'b1;
									end
									state_q <= S_SCAN;
								end
							end
							ACT_FREE: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					// one entry read per cycle, judged in the cycle after its read
					if (sel) begin
						found_q <= 1'b1;
					end
					pend_q   <= scan_issue;
					pend_a_q <= iss_j_q;
					if (scan_issue) begin
						iss_n_q <= iss_n_q + CNT_ONE;
						iss_j_q <= (CW'(iss_j_q) + CNT_ONE == count_q) ? '0 : iss_j_q + 1'b1;
					end
					if ((sel && stop_mode) || (iss_n_q == count_q && !pend_q)) begin
						state_q <= op_free ? S_FCHK : S_AFIN;
					end
				end
				S_AFIN: begin
					if (!found_q) begin
						status_q <= ST_NOFIT;
						state_q  <= S_RESP;
					end else begin
						cur_q     <= afin_cur;
						cur_vld_q <= afin_vld;
						if (split) begin
							count_q <= count_q + CNT_ONE;
							if (k_cw + CNT_ONE < count_q) begin
								// open a slot after the chosen entry
								mv_r_q    <= IW'(count_q - CNT_ONE);
								mv_last_q <= k_q + 1'b1;
								mv_up_q   <= 1'b0;
								mv_done_q <= 1'b0;
								pend_q    <= 1'b0;
								ret_q     <= S_WNEW;
								state_q   <= S_MOVE;
							end else begin
								state_q <= S_WNEW;
							end
						end else begin
							state_q <= S_WK;
						end
					end
				end
				S_MOVE: begin
					// read one entry, write it one place over on the next cycle
					pend_q   <= !mv_done_q;
					pend_a_q <= mv_r_q;
					if (!mv_done_q) begin
						if (mv_r_q == mv_last_q) begin
							mv_done_q <= 1'b1;
						end else begin
							mv_r_q <= mv_up_q ? (mv_r_q + 1'b1) : (mv_r_q - 1'b1);
						end
					end
					if (mv_done_q && !pend_q) begin
						state_q <= ret_q;
					end
				end
				S_WNEW: begin
					free_q  <= free_q - HB;
					state_q <= S_WK;
				end
				S_WK: begin
					free_q    <= free_q - k_len_q;
					granted_q <= k_start_q + HB;
					status_q  <= ST_OK;
					state_q   <= S_RESP;
				end
				S_FCHK: begin
					if (!found_q || !k_used_q) begin
						status_q <= ST_UNKNOWN;
						state_q  <= S_RESP;
					end else begin
						free_q  <= free_q + k_len_q;
						state_q <= S_FSUC;
					end
				end
				S_FSUC: begin
					state_q <= S_FPRE;
				end
				S_FPRE: begin
					cur_q     <= fpre_cur;
					cur_vld_q <= fpre_vld;
					if (succ_free_q) begin
						free_q  <= free_q + HB;
						count_q <= count_q - CNT_ONE;
						if (k_cw + CNT_TWO < count_q) begin
							// close the gap left by the successor
							mv_r_q    <= k_q + IW'(2);
							mv_last_q <= IW'(count_q - CNT_ONE);
							mv_up_q   <= 1'b1;
							mv_done_q <= 1'b0;
							pend_q    <= 1'b0;
							ret_q     <= S_FMP;
							state_q   <= S_MOVE;
						end else begin
							state_q <= S_FMP;
						end
					end else begin
						state_q <= S_FMP;
					end
				end
				S_FMP: begin
					status_q <= ST_OK;
					if (pred_free_q) begin
						cur_q     <= fmp_cur;
						cur_vld_q <= fmp_vld;
						free_q    <= free_q + HB;
						count_q   <= count_q - CNT_ONE;
						if (k_cw + CNT_ONE < count_q) begin
							// close the gap left by the freed entry
							mv_r_q    <= k_q + 1'b1;
							mv_last_q <= IW'(count_q - CNT_ONE);
							mv_up_q   <= 1'b1;
							mv_done_q <= 1'b0;
							pend_q    <= 1'b0;
							ret_q     <= S_RESP;
							state_q   <= S_MOVE;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					init_reply_q <= 1'b0;
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// channel outputs
	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = (state_q == S_RESP);
	assign status         = status_q;
	assign granted_offset = granted_q;
	assign bytes_free     = free_q;
	assign segment_total  = count_q;

	// a result beat never overlaps an accepted input beat
	a_resp_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result beat is pending");

	// the table never runs empty or past its capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_MAX))
		else $error("segment count out of range");

	// only a successful allocate reports a granted offset
	a_granted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (granted_offset == '0))
		else $error("granted offset set on a failed operation");

	// a table move only writes while a read is in flight
	a_move_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && ram_we) |-> $past(ram_raddr) == pend_a_q)
		else $error("table move wrote without a matching read");

endmodule

`default_nettype wire

[sv/fpba_ram.sv]
// fpba_ram: generic single-write, single-read memory with registered read
// no dependencies; holds the segment table
`default_nettype none

module fpba_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/fpba_scan_eval.sv]
// fpba_scan_eval: shared compare unit that judges one table entry per cycle
// depends on fpba_pkg (eval_t, policy codes)
`default_nettype none

module fpba_scan_eval #(
	parameter int OFFSET_BITS  = 16,
	parameter int HEADER_BYTES = 32
) (
	input  wire  [OFFSET_BITS-1:0] entry_start,
	input  wire  [OFFSET_BITS-1:0] entry_len,
	input  wire                    entry_used,
	input  wire  [OFFSET_BITS-1:0] request_size,
	input  wire  [OFFSET_BITS-1:0] block_offset,
	input  wire  [OFFSET_BITS-1:0] best_len,
	input  wire                    found,
	input  wire  [1:0]             policy,
	output fpba_pkg::eval_t        verdict
);

	import fpba_pkg::*;

	logic [OFFSET_BITS-1:0] data_ofs;
	logic                   fit;

	// fit test and candidate ranking
	always_comb begin
		data_ofs = entry_start + OFFSET_BITS'(HEADER_BYTES);
		fit      = !entry_used && (entry_len >= request_size);
		verdict.fit    = fit;
		verdict.select = fit && (!found ||
			(policy == POL_BEST  && entry_len < best_len) ||
			(policy == POL_WORST && entry_len > best_len));
		verdict.match  = (data_ofs == block_offset);
	end

endmodule

`default_nettype wire
